[rtl/hb11_pkg.sv]
// shared constants, types and register codes for the halfband decimator
package hb11_pkg;

   // default field widths
   localparam int SAMPLE_WIDTH_DEFAULT = 16;
   localparam int COEF_WIDTH_DEFAULT   = 18;

   // fixed point and filter shape
   localparam int FRAC_BITS    = 16;
   localparam int NUM_TAPS     = 7;
   localparam int DELAY_DEPTH  = 10;
   localparam int NUM_PSUMS    = (NUM_TAPS + 1) / 2;
   localparam int CENTER_TAP   = 3;
   localparam int CENTER_RESET = 32768;
   localparam int NUM_STAGES   = 5;

   // delay line position of each tap, 0 the oldest stored sample; DELAY_DEPTH marks the incoming sample
   localparam int TAP_POS [NUM_TAPS] = '{0, 2, 4, 5, 6, 8, 10};

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COEF_TAP0   = 3'd0,
      CSR_COEF_TAP2   = 3'd1,
      CSR_COEF_TAP4   = 3'd2,
      CSR_COEF_CENTER = 3'd3,
      CSR_COEF_TAP6   = 3'd4,
      CSR_COEF_TAP8   = 3'd5,
      CSR_COEF_TAP10  = 3'd6
   } csr_index_type;

   // per-stage load enables of the filter pipeline
   typedef struct packed {
      logic tap_en;
      logic prod_en;
      logic psum_en;
      logic sum_en;
      logic out_en;
   } pipe_ctrl_type;

endpackage

[rtl/hb11_coef_regs.sv]
// coefficient register file written through the csr port
module hb11_coef_regs #(
   parameter int COEF_WIDTH = hb11_pkg::COEF_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [hb11_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [COEF_WIDTH-1:0]                  csr_wdata,
   output logic signed [COEF_WIDTH-1:0]           coef [hb11_pkg::NUM_TAPS]
);
   import hb11_pkg::*;

   logic signed [COEF_WIDTH-1:0] coef_ff [NUM_TAPS];
   logic signed [COEF_WIDTH-1:0] coef_in [NUM_TAPS];

   // decode register writes; unknown indexes are dropped
   always_comb begin
      coef_in = coef_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_COEF_TAP0:   coef_in[0] = csr_wdata;
            CSR_COEF_TAP2:   coef_in[1] = csr_wdata;
            CSR_COEF_TAP4:   coef_in[2] = csr_wdata;
            CSR_COEF_CENTER: coef_in[3] = csr_wdata;
            CSR_COEF_TAP6:   coef_in[4] = csr_wdata;
            CSR_COEF_TAP8:   coef_in[5] = csr_wdata;
            CSR_COEF_TAP10:  coef_in[6] = csr_wdata;
            default: ;
         endcase
      end
   end

   // registers, center tap resets to one half
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_TAPS; k++) begin
            coef_ff[k] <= '0;
         end
         coef_ff[CENTER_TAP] <= COEF_WIDTH'(CENTER_RESET);
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

[rtl/hb11_delay_line.sv]
// ten-deep I/Q delay line, decimation phase and tap selection
module hb11_delay_line #(
   parameter int SAMPLE_WIDTH = hb11_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic signed [SAMPLE_WIDTH-1:0]   in_i,
   input  logic signed [SAMPLE_WIDTH-1:0]   in_q,
   output logic signed [SAMPLE_WIDTH-1:0]   taps_i [hb11_pkg::NUM_TAPS],
   output logic signed [SAMPLE_WIDTH-1:0]   taps_q [hb11_pkg::NUM_TAPS],
   output logic                             emit
);
   import hb11_pkg::*;

   logic signed [SAMPLE_WIDTH-1:0] dly_i_ff [DELAY_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] dly_q_ff [DELAY_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] dly_i_in [DELAY_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] dly_q_in [DELAY_DEPTH];
   logic                           odd_phase_ff;
   logic                           odd_phase_in;

   // shift on every transfer, newest at the top
   always_comb begin
      dly_i_in     = dly_i_ff;
      dly_q_in     = dly_q_ff;
      odd_phase_in = odd_phase_ff;
      if (accept) begin
         for (int k = 0; k < DELAY_DEPTH - 1; k++) begin
            dly_i_in[k] = dly_i_ff[k + 1];
            dly_q_in[k] = dly_q_ff[k + 1];
         end
         dly_i_in[DELAY_DEPTH - 1] = in_i;
         dly_q_in[DELAY_DEPTH - 1] = in_q;
         odd_phase_in              = ~odd_phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DELAY_DEPTH; k++) begin
            dly_i_ff[k] <= '0;
            dly_q_ff[k] <= '0;
         end
         odd_phase_ff <= 1'b0;
      end else begin
         dly_i_ff     <= dly_i_in;
         dly_q_ff     <= dly_q_in;
         odd_phase_ff <= odd_phase_in;
      end
   end

   // window seen by the incoming sample
   for (genvar k = 0; k < NUM_TAPS; k++) begin : g_tap
      if (TAP_POS[k] == DELAY_DEPTH) begin : g_newest
         assign taps_i[k] = in_i;
         assign taps_q[k] = in_q;
      end else begin : g_stored
         assign taps_i[k] = dly_i_ff[TAP_POS[k]];
         assign taps_q[k] = dly_q_ff[TAP_POS[k]];
      end
   end

   assign emit = ~odd_phase_ff;

endmodule

[rtl/hb11_mac_rail.sv]
// one rail of the filter: tap capture, products, adder tree, round, saturate
module hb11_mac_rail #(
   parameter int SAMPLE_WIDTH = hb11_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int COEF_WIDTH   = hb11_pkg::COEF_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  hb11_pkg::pipe_ctrl_type          ctrl,
   input  logic signed [SAMPLE_WIDTH-1:0]   taps [hb11_pkg::NUM_TAPS],
   input  logic signed [COEF_WIDTH-1:0]     coef [hb11_pkg::NUM_TAPS],
   output logic signed [SAMPLE_WIDTH-1:0]   result
);
   import hb11_pkg::*;

   localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int PSUM_WIDTH = PROD_WIDTH + 1;
   localparam int SUM_WIDTH  = PROD_WIDTH + 3;

   localparam logic signed [SUM_WIDTH-1:0] ROUND_HALF =
      {{(SUM_WIDTH - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
   localparam logic signed [SUM_WIDTH-1:0] SAT_MAX =
      {{(SUM_WIDTH - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SAT_MIN =
      {{(SUM_WIDTH - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

   logic signed [SAMPLE_WIDTH-1:0] tap_ff  [NUM_TAPS];
   logic signed [PROD_WIDTH-1:0]   prod_ff [NUM_TAPS];
   logic signed [PROD_WIDTH-1:0]   prod_in [NUM_TAPS];
   logic signed [PSUM_WIDTH-1:0]   psum_ff [NUM_PSUMS];
   logic signed [PSUM_WIDTH-1:0]   psum_in [NUM_PSUMS];
   logic signed [SUM_WIDTH-1:0]    total;
   logic signed [SUM_WIDTH-1:0]    rsum_ff;
   logic signed [SUM_WIDTH-1:0]    rsum_in;
   logic signed [SAMPLE_WIDTH-1:0] out_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_in;

   // exact products, one multiplier per tap
   always_comb begin
      for (int k = 0; k < NUM_TAPS; k++) begin
         prod_in[k] = PROD_WIDTH'(tap_ff[k]) * PROD_WIDTH'(coef[k]);
      end
   end

   // pairwise partial sums, odd tap count leaves the last one alone
   always_comb begin
      for (int k = 0; k < NUM_PSUMS; k++) begin
         if (2 * k + 1 < NUM_TAPS) begin
            psum_in[k] = PSUM_WIDTH'(prod_ff[2 * k]) + PSUM_WIDTH'(prod_ff[2 * k + 1]);
         end else begin
            psum_in[k] = PSUM_WIDTH'(prod_ff[2 * k]);
         end
      end
   end

   // final sum, round half up and drop the fraction bits
   always_comb begin
      total = '0;
      for (int k = 0; k < NUM_PSUMS; k++) begin
         total = total + SUM_WIDTH'(psum_ff[k]);
      end
      rsum_in = (total + ROUND_HALF) >>> FRAC_BITS;
   end

   // clamp to the sample range
   always_comb begin
      if (rsum_ff > SAT_MAX) begin
         out_in = SAT_MAX[SAMPLE_WIDTH-1:0];
      end else if (rsum_ff < SAT_MIN) begin
         out_in = SAT_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         out_in = rsum_ff[SAMPLE_WIDTH-1:0];
      end
   end

   // pipeline payload registers
   always_ff @(posedge clock) begin
      if (ctrl.tap_en) begin
         tap_ff <= taps;
      end
      if (ctrl.prod_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.psum_en) begin
         psum_ff <= psum_in;
      end
      if (ctrl.sum_en) begin
         rsum_ff <= rsum_in;
      end
      if (ctrl.out_en) begin
         out_ff <= out_in;
      end
   end

   assign result = out_ff;

endmodule

[rtl/halfband11_decimate_by_two.sv]
// Halfband 11-tap FIR decimator by two for a complex I/Q sample stream.
// One sample is taken per clock unless req_stall holds it; every other
// sample, starting with the first after reset, yields one filtered I/Q
// result. The filter is a five-stage pipeline (tap capture, multiply, pair
// add, final add with rounding, saturation) that holds up to five results
// in flight; an even sample's result moves through the tap, product, partial
// sum, rounded sum and output registers. Each stage loads whenever it is
// empty or the stage after it moves, so input keeps flowing while a result
// waits on a stalled output until the pipeline is full. The user must
// write coefficients through the csr port while the block is idle; the
// block does not enforce it. The center tap resets to one half, all others to zero.
module halfband11_decimate_by_two #(
   parameter int SAMPLE_WIDTH = hb11_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int COEF_WIDTH   = hb11_pkg::COEF_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_in_i,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_in_q,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_out_i,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_out_q,
   // configuration port
   input  logic                                   csr_wr_en,
   input  logic [hb11_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [COEF_WIDTH-1:0]                  csr_wdata
);
   import hb11_pkg::*;

   logic signed [COEF_WIDTH-1:0]   coef   [NUM_TAPS];
   logic signed [SAMPLE_WIDTH-1:0] taps_i [NUM_TAPS];
   logic signed [SAMPLE_WIDTH-1:0] taps_q [NUM_TAPS];
   logic                           emit;
   logic                           accept;
   logic [NUM_STAGES-1:0]          stage_valid_ff;
   logic [NUM_STAGES-1:0]          stage_valid_in;
   logic [NUM_STAGES-1:0]          stage_en;
   pipe_ctrl_type                  ctrl;

   // a stage loads when empty or when its successor moves
   always_comb begin
      stage_en[NUM_STAGES-1] = ~stage_valid_ff[NUM_STAGES-1] | ~rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = ~stage_valid_ff[k] | stage_en[k + 1];
      end
   end

   assign req_stall = ~stage_en[0];
   assign accept    = req_valid & ~req_stall;

   // valid bits follow the payload through the stages
   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (stage_en[0]) begin
         stage_valid_in[0] = accept & emit;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (stage_en[k]) begin
            stage_valid_in[k] = stage_valid_ff[k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   assign ctrl.tap_en  = stage_en[0];
   assign ctrl.prod_en = stage_en[1];
   assign ctrl.psum_en = stage_en[2];
   assign ctrl.sum_en  = stage_en[3];
   assign ctrl.out_en  = stage_en[4];

   assign rsp_valid = stage_valid_ff[NUM_STAGES-1];

   hb11_coef_regs #(
      .COEF_WIDTH (COEF_WIDTH)
   ) u_coef_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   hb11_delay_line #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_delay_line (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .in_i   (req_in_i),
      .in_q   (req_in_q),
      .taps_i (taps_i),
      .taps_q (taps_q),
      .emit   (emit)
   );

   hb11_mac_rail #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_rail_i (
      .clock  (clock),
      .ctrl   (ctrl),
      .taps   (taps_i),
      .coef   (coef),
      .result (rsp_out_i)
   );

   hb11_mac_rail #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_rail_q (
      .clock  (clock),
      .ctrl   (ctrl),
      .taps   (taps_q),
      .coef   (coef),
      .result (rsp_out_q)
   );

endmodule

[rtl/hb11_checker.sv]
// port-level checks of the halfband decimator, bound to the top level
module hb11_checker #(
   parameter int SAMPLE_WIDTH = hb11_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_out_i,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_out_q
);

   // no result is left over from before reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a moving or empty output never backs up the input
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled while output is free");

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_out_i) && $stable(rsp_out_q)))
      else $error("result changed while stalled");

endmodule

bind halfband11_decimate_by_two hb11_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_hb11_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_out_i (rsp_out_i),
   .rsp_out_q (rsp_out_q)
);

[dv/halfband11_result_check.sv]
// result checker for the halfband decimator: predicts every decimated I/Q pair and compares
`timescale 1ns / 1ps
module halfband11_result_check #(
   parameter int SAMPLE_WIDTH = hb11_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int COEF_WIDTH   = hb11_pkg::COEF_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_in_i,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_in_q,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]       rsp_out_i,
   input  logic signed [SAMPLE_WIDTH-1:0]       rsp_out_q,
   input  logic                                 csr_wr_en,
   input  logic [hb11_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]                csr_wdata,
   output int                                   mismatch_count,
   output int                                   pending_results,
   output int                                   results_seen
);
   import hb11_pkg::*;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
   typedef struct packed {
      sample_t out_i;
      sample_t out_q;
   } iq_pair_t;

   localparam longint SAT_HIGH   = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
   localparam longint SAT_LOW    = -SAT_HIGH - 1;
   localparam longint ROUND_HALF = longint'(1) <<< (FRAC_BITS - 1);

   // predicted results not yet seen on the output, oldest first
   iq_pair_t decimated_fifo[$];

   // filter state: delay lines with index 0 the oldest sample, phase bit, coefficients
   sample_t  line_i [DELAY_DEPTH];
   sample_t  line_q [DELAY_DEPTH];
   longint   coef [NUM_TAPS];
   bit       odd_phase;
   int       mismatches;
   int       seen;

   // exact weighted sum over the taps, round half up, saturate to the sample range
   function automatic sample_t filter_rail(input bit quad_rail, input sample_t newest);
      longint acc;
      longint tap;
      acc = 0;
      for (int k = 0; k < NUM_TAPS; k++) begin
         if (TAP_POS[k] == DELAY_DEPTH)
            tap = newest;
         else if (quad_rail)
            tap = line_q[TAP_POS[k]];
         else
            tap = line_i[TAP_POS[k]];
         acc += tap * coef[k];
      end
      acc = (acc + ROUND_HALF) >>> FRAC_BITS;
      if (acc > SAT_HIGH)
         acc = SAT_HIGH;
      if (acc < SAT_LOW)
         acc = SAT_LOW;
      return sample_t'(acc);
   endfunction

   task automatic compare_rail(input string rail, input sample_t want, input sample_t got);
      if (got !== want) begin
         $display("%0t %s mismatch: expected %0d, actual %0d", $time, rail, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      iq_pair_t want;
      if (reset) begin
         for (int k = 0; k < NUM_TAPS; k++)
            coef[k] = 0;
         coef[CENTER_TAP] = CENTER_RESET;
         for (int k = 0; k < DELAY_DEPTH; k++) begin
            line_i[k] = '0;
            line_q[k] = '0;
         end
         odd_phase = 1'b0;
         decimated_fifo.delete();
      end else begin
         // coefficient writes; indexes past the last tap are dropped
         if (csr_wr_en && csr_index < NUM_TAPS)
            coef[csr_index] = signed'(csr_wdata);

         // output transfer against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            seen++;
            if (decimated_fifo.size() == 0) begin
               $display("%0t unexpected result: i %0d q %0d", $time, rsp_out_i, rsp_out_q);
               mismatches++;
            end else begin
               want = decimated_fifo.pop_front();
               compare_rail("out_i", want.out_i, rsp_out_i);
               compare_rail("out_q", want.out_q, rsp_out_q);
            end
         end

         // input transfer: even samples emit, every sample shifts in
         if (req_valid && !req_stall) begin
            if (!odd_phase)
               decimated_fifo.push_back({filter_rail(1'b0, req_in_i),
                                         filter_rail(1'b1, req_in_q)});
            for (int k = 0; k < DELAY_DEPTH - 1; k++) begin
               line_i[k] = line_i[k + 1];
               line_q[k] = line_q[k + 1];
            end
            line_i[DELAY_DEPTH - 1] = req_in_i;
            line_q[DELAY_DEPTH - 1] = req_in_q;
            odd_phase = !odd_phase;
         end
      end
      mismatch_count  <= mismatches;
      pending_results <= decimated_fifo.size();
      results_seen    <= seen;
   end

endmodule

[dv/halfband11_decimate_by_two_tb.sv]
// testbench top for the halfband decimator: clock, reset, stimulus, output stalls and verdict
`timescale 1ns / 1ps
module halfband11_decimate_by_two_tb;
   import hb11_pkg::*;

   localparam int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT;
   localparam int COEF_WIDTH   = COEF_WIDTH_DEFAULT;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
   typedef logic signed [COEF_WIDTH-1:0]   coef_t;
   typedef enum int {COEFS_FULL, COEFS_EXTREME, COEFS_GENTLE} coef_style_t;

   localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
   localparam coef_t   COEF_MAX   = {1'b0, {(COEF_WIDTH - 1){1'b1}}};
   localparam coef_t   COEF_MIN   = {1'b1, {(COEF_WIDTH - 1){1'b0}}};
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = {CSR_INDEX_WIDTH{1'b1}};

   localparam int NUM_PHASES      = 8;
   localparam int PHASE_SAMPLES   = 250;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int SETTLE_CYCLES   = 10;
   localparam int RESET_CYCLES    = 8;

   // samples for the center tap at its reset value of one half: rounding of halves
   localparam int CENTER_PROBE [12] = '{0, 1, 0, -1, 0, 32767, 0, -32768, 0, 3, 0, -3};

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   sample_t                    req_in_i = '0;
   sample_t                    req_in_q = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   sample_t                    rsp_out_i;
   sample_t                    rsp_out_q;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [COEF_WIDTH-1:0]      csr_wdata = '0;

   int      mismatch_count;
   int      pending_results;
   int      results_seen;
   int      stuck_count = 0;
   int      samples_sent = 0;
   int      settings_loaded = 0;
   int      stall_hold = 0;
   bit      quiet_phase = 1'b0;
   coef_t   coef_set [NUM_TAPS];
   sample_t last_i = '0;
   sample_t last_q = '0;

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   halfband11_decimate_by_two dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_in_i  (req_in_i),
      .req_in_q  (req_in_q),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out_i (rsp_out_i),
      .rsp_out_q (rsp_out_q),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   halfband11_result_check #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) decim_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_i        (req_in_i),
      .req_in_q        (req_in_q),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_i       (rsp_out_i),
      .rsp_out_q       (rsp_out_q),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .results_seen    (results_seen)
   );

   // output stalls: mostly short runs, a few long ones, none in quiet phases
   always @(posedge clock) begin
      int pick;
      if (reset || quiet_phase) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            rsp_stall  <= 1'b0;
            stall_hold <= $urandom_range(0, 4);
         end else if (pick < 95) begin
            rsp_stall  <= 1'b1;
            stall_hold <= $urandom_range(0, 3);
         end else begin
            rsp_stall  <= 1'b1;
            stall_hold <= $urandom_range(10, 40);
         end
      end
   end

   // one sample transfer; returns at the edge that accepted it
   task automatic send_sample(input sample_t i_val, input sample_t q_val);
      req_valid <= 1'b1;
      req_in_i  <= i_val;
      req_in_q  <= q_val;
      do
         @(posedge clock);
      while (!(req_valid && !req_stall));
      samples_sent++;
      last_i = i_val;
      last_q = q_val;
   endtask

   // random hole in the input stream
   task automatic request_gap();
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      if (quiet_phase || pick < 60)
         len = 0;
      else if (pick < 92)
         len = $urandom_range(1, 3);
      else
         len = $urandom_range(5, 30);
      if (len > 0) begin
         req_valid <= 1'b0;
         repeat (len) @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx, input coef_t value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // write all seven coefficients, optionally poke the index past the last tap
   task automatic load_coef_set(input bit poke_unused);
      for (int k = 0; k < NUM_TAPS; k++)
         csr_write(csr_index_type'(k), coef_set[k]);
      if (poke_unused)
         csr_write(CSR_UNUSED_INDEX, coef_t'($urandom));
      csr_wr_en <= 1'b0;
      settings_loaded++;
   endtask

   // wait for every predicted result, then let the pipeline settle
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending_results != 0 && waited < DRAIN_LIMIT);
      if (pending_results != 0) begin
         $display("%0t results still outstanding: %0d", $time, pending_results);
         stuck_count++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic sample_t rand_sample(input sample_t prev_val);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         return sample_t'($urandom);
      if (pick < 85 && pick >= 65)
         return sample_t'($urandom_range(0, 512)) - sample_t'(256);
      if (pick >= 85)
         return prev_val;
      case ($urandom_range(0, 4))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         3:       return sample_t'(1);
         default: return '1;
      endcase
   endfunction

   function automatic coef_t rand_coef(input coef_style_t style);
      case (style)
         COEFS_EXTREME: begin
            case ($urandom_range(0, 4))
               0:       return COEF_MAX;
               1:       return COEF_MIN;
               2:       return '0;
               3:       return coef_t'(1);
               default: return '1;
            endcase
         end
         COEFS_GENTLE: return coef_t'($urandom_range(0, 32768)) - coef_t'(16384);
         default:      return coef_t'($urandom);
      endcase
   endfunction

   // hard stop in case the run hangs
   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   // stimulus and verdict
   initial begin
      coef_style_t style;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // center tap alone at one half: rounding of exact halves in both signs
      for (int k = 0; k < 12; k++) begin
         send_sample(sample_t'(CENTER_PROBE[k]), ~sample_t'(CENTER_PROBE[k]));
         request_gap();
      end

      // all coefficients at the positive limit: saturation both ways
      drain();
      for (int k = 0; k < NUM_TAPS; k++)
         coef_set[k] = COEF_MAX;
      load_coef_set(1'b1);
      for (int k = 0; k < 8; k++) begin
         if (k < 4)
            send_sample(SAMPLE_MAX, SAMPLE_MIN);
         else
            send_sample(SAMPLE_MIN, SAMPLE_MAX);
         request_gap();
      end

      // all coefficients at the negative limit
      drain();
      for (int k = 0; k < NUM_TAPS; k++)
         coef_set[k] = COEF_MIN;
      load_coef_set(1'b0);
      for (int k = 0; k < 5; k++) begin
         if (k < 3)
            send_sample(SAMPLE_MIN, SAMPLE_MAX);
         else
            send_sample(SAMPLE_MAX, SAMPLE_MIN);
         request_gap();
      end

      // random phases, each under a fresh coefficient setting
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         style = coef_style_t'(p % 3);
         for (int k = 0; k < NUM_TAPS; k++)
            coef_set[k] = rand_coef(style);
         if (style == COEFS_GENTLE)
            coef_set[CENTER_TAP] = coef_t'(CENTER_RESET);
         load_coef_set(1'($urandom_range(0, 1)));
         quiet_phase <= (p % 4 == 3);
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            send_sample(rand_sample(last_i), rand_sample(last_q));
            request_gap();
         end
      end
      drain();

      $display("%0d samples sent under %0d coefficient settings, %0d decimated results checked",
               samples_sent, settings_loaded, results_seen);
      if (mismatch_count == 0 && stuck_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
